@@ sv/swm_pkg.sv @@
// Shared constants and types for the sliding window median filter.
`default_nettype none

package swm_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DEF_MAX_WINDOW   = 32;
  localparam int DEF_SAMPLE_WIDTH = 32;

  // Configuration port
  localparam int CFG_WIDTH      = 6;
  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;

  // Register index taken from paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;

  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = CFG_WIDTH'(3);

  // Status handed from one cell to its right neighbor
  typedef struct packed {
    logic gt;      // compacted entry of this cell sorts after the new key
    logic removed; // the oldest entry sits at or below this cell
  } swm_link_t;

  // Broadcast control for every cell
  typedef struct packed {
    logic upd;  // an item is accepted this cycle
    logic full; // window was full before this item
  } swm_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sliding_window_median_core.sv @@
// Top level of the sliding window median filter: config port, cell row, result stage.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------
//  input    | sample_valid / sample_stall | sample, last_sample
//  output   | median_valid / median_stall | median, last_out
//  config   | psel, penable, pwrite       | paddr, pwdata, prdata
//
// One item is taken per clock while sample_stall is low; the whole row of cells
// drops the oldest sample and inserts the new one in the cycle the item is
// accepted. The median waits in the row until the output register is free or
// being taken, and is copied into that register. Synchronous reset empties the
// window and restores a window of three. A stalled output holds its result; the
// input stalls only while a finished median is still waiting for the output register.
`default_nettype none

module sliding_window_median_core #(
  parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [swm_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  wire logic [swm_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic      [swm_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                      pready,
  // input channel
  input  wire logic                                 sample_valid,
  output logic                                      sample_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sample,
  input  wire logic                                 last_sample,
  // output channel
  output logic                                      median_valid,
  input  wire logic                                 median_stall,
  output logic signed [SAMPLE_WIDTH-1:0]            median,
  output logic                                      last_out
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // Configuration register
  logic [CFG_WIDTH-1:0] window_size;
  logic                 cfg_write;

  // Window control
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] eff_size;
  logic [CW-1:0] limit;
  logic [AW-1:0] oldest_age;
  logic [AW-1:0] mid;
  logic          accept;
  logic          produce;
  swm_ctrl_t     ctrl;

  // Result stage
  logic pend_valid;
  logic pend_last;
  logic move;

  // Cell row wiring
  logic signed [SAMPLE_WIDTH-1:0] cell_val  [MAX_WINDOW];
  logic        [AW-1:0]           cell_age  [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] comp_val  [MAX_WINDOW];
  logic        [AW-1:0]           comp_age  [MAX_WINDOW];
  swm_link_t                      cell_link [MAX_WINDOW];

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_SIZE) begin
      prdata[CFG_WIDTH-1:0] = window_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (cfg_write) begin
      window_size <= pwdata[CFG_WIDTH-1:0];
    end
  end

  // Zero acts as one, anything above the row length saturates.
  always_comb begin
    if (window_size == '0) begin
      eff_size = CW'(1);
    end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
      eff_size = CW'(MAX_WINDOW);
    end else begin
      eff_size = CW'(window_size);
    end
  end

  // ---------------------------------------------------------------- control
  assign move         = pend_valid && (!median_valid || !median_stall);
  assign sample_stall = pend_valid && !move;
  assign accept       = sample_valid && !sample_stall;

  assign ctrl.upd   = accept;
  assign ctrl.full  = (fill >= eff_size);
  // Entries that take part in the insert: all held ones, less the dropped one.
  assign limit      = ctrl.full ? CW'(eff_size - 1'b1) : fill;
  assign oldest_age = AW'(eff_size - 1'b1);
  assign mid        = AW'((eff_size - 1'b1) >> 1);

  always_comb begin
    if (ctrl.full) begin
      fill_next = eff_size;
    end else begin
      fill_next = CW'(fill + 1'b1);
    end
  end

  assign produce = (fill_next >= eff_size);

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      fill <= '0;
    end else if (accept) begin
      // Clear the window after the last item of a sequence.
      fill <= last_sample ? '0 : fill_next;
    end
  end

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] l_val;
    logic        [AW-1:0]           l_age;
    swm_link_t                      l_link;
    logic signed [SAMPLE_WIDTH-1:0] r_val;
    logic        [AW-1:0]           r_age;

    if (i == 0) begin : g_left_edge
      assign l_val  = '0;
      assign l_age  = '0;
      assign l_link = '0;
    end else begin : g_left
      assign l_val  = comp_val[i-1];
      assign l_age  = comp_age[i-1];
      assign l_link = cell_link[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_right_edge
      assign r_val = '0;
      assign r_age = '0;
    end else begin : g_right
      assign r_val = cell_val[i+1];
      assign r_age = cell_age[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_WIDTH    (AW),
      .CNT_WIDTH    (CW),
      .IDX          (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key        (sample),
      .limit      (limit),
      .fill       (fill),
      .oldest_age (oldest_age),
      .left_val   (l_val),
      .left_age   (l_age),
      .left_link  (l_link),
      .right_val  (r_val),
      .right_age  (r_age),
      .val        (cell_val[i]),
      .age        (cell_age[i]),
      .comp_val   (comp_val[i]),
      .comp_age   (comp_age[i]),
      .link       (cell_link[i])
    );
  end

  // ---------------------------------------------------------------- results
  // Hold a pending result until the output register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= produce;
    end else if (move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_last <= last_sample;
    end
  end

  // Advance the median from the row into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (move) begin
      median_valid <= 1'b1;
    end else if (!median_stall) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      median   <= cell_val[mid];
      last_out <= pend_last;
    end
  end

endmodule

`default_nettype wire

@@ sv/swm_cell.sv @@
// One cell of the sorted window: holds one sample and its age.
`default_nettype none

module swm_cell #(
  parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH,
  parameter int AGE_WIDTH    = 5,
  parameter int CNT_WIDTH    = 6,
  parameter int IDX          = 0
) (
  input  wire logic                           clk,
  input  wire swm_pkg::swm_ctrl_t             ctrl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] key,
  input  wire logic        [CNT_WIDTH-1:0]    limit,
  input  wire logic        [CNT_WIDTH-1:0]    fill,
  input  wire logic        [AGE_WIDTH-1:0]    oldest_age,
  // from the left neighbor (compacted entry)
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_val,
  input  wire logic        [AGE_WIDTH-1:0]    left_age,
  input  wire swm_pkg::swm_link_t             left_link,
  // from the right neighbor (stored entry)
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_val,
  input  wire logic        [AGE_WIDTH-1:0]    right_age,
  // stored entry
  output logic signed      [SAMPLE_WIDTH-1:0] val,
  output logic             [AGE_WIDTH-1:0]    age,
  // compacted entry for the right neighbor
  output logic signed      [SAMPLE_WIDTH-1:0] comp_val,
  output logic             [AGE_WIDTH-1:0]    comp_age,
  output swm_pkg::swm_link_t                  link
);
  import swm_pkg::*;

  logic                           is_oldest;
  logic signed [SAMPLE_WIDTH-1:0] val_next;
  logic        [AGE_WIDTH-1:0]    age_next;

  // Drop the oldest entry: cells at and above it take the right neighbor's entry.
  assign is_oldest    = ctrl.full && (CNT_WIDTH'(IDX) < fill) && (age == oldest_age);
  assign link.removed = left_link.removed | is_oldest;
  assign comp_val     = link.removed ? right_val : val;
  assign comp_age     = link.removed ? right_age : age;
  assign link.gt      = (CNT_WIDTH'(IDX) >= limit) || (comp_val > key);

  // Insert the new key after all entries that do not sort after it.
  always_comb begin
    if (!link.gt) begin
      val_next = comp_val;
      age_next = AGE_WIDTH'(comp_age + 1'b1);
    end else if (IDX == 0 || !left_link.gt) begin
      val_next = key;
      age_next = '0;
    end else begin
      val_next = left_val;
      age_next = AGE_WIDTH'(left_age + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

`default_nettype wire

@@ sim/sliding_window_median_core_test.sv @@
// Self-checking testbench for the sliding window median filter core.
`timescale 1ns / 1ps

module sliding_window_median_core_test;

  localparam int SW  = swm_pkg::DEF_SAMPLE_WIDTH;
  localparam int MAXW = swm_pkg::DEF_MAX_WINDOW;
  localparam int CW  = swm_pkg::CFG_WIDTH;

  // Register 0 sits at byte address 0; paddr[2] selects the register
  localparam logic [swm_pkg::APB_ADDR_WIDTH-1:0] WINDOW_SIZE_ADDR =
    {swm_pkg::REG_WINDOW_SIZE, 2'b00};

  // Slack to let the pipeline settle after the medians are drained
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef struct packed {
    sample_t median;
    logic    last;
  } median_result_t;

  // Value flavors for random sequences
  typedef enum int {VALUES_WIDE, VALUES_NARROW, VALUES_EDGE} value_mix_t;
  // Sequence shapes: complete window runs, runs cut short by last, and noise
  typedef enum int {SEQ_FULL, SEQ_SHORT, SEQ_NOISE} seq_kind_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [swm_pkg::APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [swm_pkg::APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [swm_pkg::APB_DATA_WIDTH-1:0] prdata;
  logic                              pready;
  logic                              sample_valid = 1'b0;
  logic                              sample_stall;
  sample_t                           sample = '0;
  logic                              last_sample = 1'b0;
  logic                              median_valid;
  logic                              median_stall = 1'b0;
  sample_t                           median;
  logic                              last_out;

  sliding_window_median_core #(
    .MAX_WINDOW  (MAXW),
    .SAMPLE_WIDTH(SW)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .median_valid(median_valid),
    .median_stall(median_stall),
    .median      (median),
    .last_out    (last_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the filter state: arrival ring, sorted window, ring pointer, fill level
  sample_t           arrival_ring[MAXW];
  sample_t           sorted_window[MAXW];
  int                oldest_slot = 0;
  int                held_count  = 0;
  logic [CW-1:0]     window_reg  = swm_pkg::WINDOW_SIZE_RESET;

  median_result_t    expected_medians[$];
  int                mismatch_count = 0;
  int                quiet_cycles   = 0;

  // Idling knobs shared by the sender, the receiver and the test tasks
  int                sample_gap_max = 5;
  int                stall_max      = 5;
  int                hold_cycles    = 0;

  // Size zero acts as one, sizes past the store saturate
  function automatic int active_window();
    int w;
    w = window_reg;
    if (w == 0) w = 1;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  // Push one sample through the window; returns 1 when it yields a median
  function automatic bit advance_window(input sample_t value, input logic last_flag,
                                        output median_result_t result);
    int w;
    int slot;
    int i;
    bit produced;
    w = active_window();
    produced = 1'b0;
    result = '0;
    if (held_count >= w) begin
      // Drop the oldest sample from the sorted view, then insert the new one
      slot = oldest_slot % w;
      i = 0;
      while (i < w && sorted_window[i] != arrival_ring[slot]) i++;
      if (i < w) begin
        for (int j = i; j + 1 < w; j++) sorted_window[j] = sorted_window[j + 1];
      end
      i = w - 1;
      while (i > 0 && sorted_window[i - 1] > value) begin
        sorted_window[i] = sorted_window[i - 1];
        i--;
      end
      sorted_window[i] = value;
      arrival_ring[slot] = value;
      oldest_slot = (slot + 1) % w;
      held_count = w;
    end else begin
      arrival_ring[held_count] = value;
      i = held_count;
      while (i > 0 && sorted_window[i - 1] > value) begin
        sorted_window[i] = sorted_window[i - 1];
        i--;
      end
      sorted_window[i] = value;
      held_count++;
      oldest_slot = 0;
    end
    if (held_count >= w) begin
      result.median = sorted_window[(w - 1) / 2];
      result.last = last_flag;
      produced = 1'b1;
    end
    if (last_flag) begin
      held_count = 0;
      oldest_slot = 0;
    end
    return produced;
  endfunction

  function automatic void flag_mismatch(input string what, input longint want,
                                        input longint got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
  endfunction

  function automatic sample_t draw_sample(input value_mix_t mix);
    case (mix)
      VALUES_WIDE:   return sample_t'($urandom);
      VALUES_NARROW: return sample_t'(int'($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 5))
          0:       return SAMPLE_MIN;
          1:       return SAMPLE_MAX;
          2:       return sample_t'(0);
          3:       return sample_t'(-1);
          4:       return sample_t'(1);
          default: return sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Offer one item, hold it until accepted, then record its expected median.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_item(input sample_t value, input logic last_flag);
    int gap;
    median_result_t result;
    gap = $urandom_range(0, sample_gap_max);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample       <= value;
    last_sample  <= last_flag;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    if (advance_window(value, last_flag, result))
      expected_medians.insert(expected_medians.size(), result);
  endtask

  // Stop offering, wait for every outstanding median, let the pipeline settle
  task automatic drain_medians();
    sample_valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write window_size while the filter is idle, then read it back
  task automatic write_window(input logic [swm_pkg::APB_DATA_WIDTH-1:0] data);
    drain_medians();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= WINDOW_SIZE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Any write empties the window
    window_reg  = data[CW-1:0];
    held_count  = 0;
    oldest_slot = 0;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CW-1:0] !== window_reg)
      flag_mismatch("window_size readback", longint'(window_reg), longint'(prdata[CW-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_sequence(input int w, inout int sent);
    value_mix_t mix;
    seq_kind_t  kind;
    int         len;
    int         pick;
    logic       flag;
    pick = $urandom_range(0, 9);
    mix  = value_mix_t'($urandom_range(0, 2));
    if (pick < 7 || w == 1) kind = SEQ_FULL;
    else if (pick < 9) kind = SEQ_SHORT;
    else kind = SEQ_NOISE;
    case (kind)
      SEQ_FULL:  len = w + int'($urandom_range(0, w + 8));
      SEQ_SHORT: len = $urandom_range(1, w - 1);
      default:   len = $urandom_range(1, 20);
    endcase
    for (int i = 0; i < len; i++) begin
      // Noise scatters last flags; other shapes close with one
      flag = (kind == SEQ_NOISE) ? ($urandom_range(0, 7) == 0) : (i == len - 1);
      send_item(draw_sample(mix), flag);
    end
    sent += len;
    // Now and then pause the sender until every median is back
    if ($urandom_range(0, 7) == 0) drain_medians();
  endtask

  // Default window of three: extremes, ties, early last, clearing by a write
  task automatic test_directed_default();
    send_item(sample_t'(5), 1'b0);
    send_item(sample_t'(-7), 1'b0);
    send_item(sample_t'(2), 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(sample_t'(0), 1'b0);
    send_item(sample_t'(-1), 1'b0);
    send_item(sample_t'(1), 1'b1);
    // Equal samples
    send_item(sample_t'(4), 1'b0);
    send_item(sample_t'(4), 1'b0);
    send_item(sample_t'(4), 1'b1);
    // Last before the window fills: no median, window cleared
    send_item(sample_t'(9), 1'b1);
    // Partial window thrown away by a rewrite of the same size
    send_item(sample_t'(-3), 1'b0);
    send_item(sample_t'(8), 1'b0);
    write_window(swm_pkg::APB_DATA_WIDTH'(3));
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MIN, 1'b1);
    // Size zero behaves as a window of one
    write_window(swm_pkg::APB_DATA_WIDTH'(0));
    send_item(SAMPLE_MAX, 1'b0);
    send_item(sample_t'(-5), 1'b1);
    // Even size takes the lower median
    write_window(swm_pkg::APB_DATA_WIDTH'(2));
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b1);
  endtask

  // Sweep window sizes, extremes and saturating values included
  task automatic test_random_sequences();
    int sizes[15] = '{1, 2, 3, 4, 5, 8, 15, 16, 31, 32, 0, 33, 63, 0, 0};
    logic [swm_pkg::APB_DATA_WIDTH-1:0] data;
    int sent;
    sizes[13] = $urandom_range(1, MAXW);
    sizes[14] = $urandom_range(1, MAXW);
    foreach (sizes[k]) begin
      data = $urandom;
      if ($urandom_range(0, 1) == 0) data[swm_pkg::APB_DATA_WIDTH-1:CW] = '0;
      data[CW-1:0] = sizes[k][CW-1:0];
      write_window(data);
      sent = 0;
      while (sent < 75) send_random_sequence(active_window(), sent);
    end
  endtask

  // Hold the output off for a long stretch while the sender keeps pushing
  task automatic test_output_hold();
    write_window(swm_pkg::APB_DATA_WIDTH'(5));
    sample_gap_max = 0;
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 60; i++) send_item(draw_sample(VALUES_WIDE), (i % 20) == 19);
    sample_gap_max = 5;
    drain_medians();
  endtask

  // No gaps or stalls on either side: one item per clock between occasional drains
  task automatic test_full_rate();
    int sent;
    write_window(swm_pkg::APB_DATA_WIDTH'(7));
    sample_gap_max = 0;
    stall_max = 0;
    sent = 0;
    while (sent < 120) send_random_sequence(active_window(), sent);
    drain_medians();
    sample_gap_max = 5;
    stall_max = 5;
  endtask

  // Receiver: draw a stall per result, honor a long hold when asked
  initial begin : drive_median_stall
    int n;
    forever begin
      if (hold_cycles > 0) begin
        median_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      n = $urandom_range(0, stall_max);
      if (n > 0) begin
        median_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      median_stall <= 1'b0;
      do @(posedge clk);
      while (!(median_valid && !median_stall) && hold_cycles == 0);
    end
  end

  // Compare each accepted median with the oldest expectation
  always @(posedge clk) begin : check_medians
    median_result_t want;
    if (!rst && median_valid && !median_stall) begin
      if (expected_medians.size() == 0) begin
        flag_mismatch("median with none pending", 0, longint'(median));
      end else begin
        want = expected_medians.pop_front();
        if (median !== want.median)
          flag_mismatch("median", longint'(want.median), longint'(median));
        if (last_out !== want.last)
          flag_mismatch("last_out", longint'(want.last), longint'(last_out));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || psel || (sample_valid && !sample_stall) || (median_valid && !median_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : run_tests
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_default();
    test_random_sequences();
    test_output_hold();
    test_full_rate();
    drain_medians();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_medians.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/swm_pkg.sv
sv/swm_cell.sv
sv/sliding_window_median_core.sv
sim/sliding_window_median_core_test.sv
